@@ rtl/core/assert_macros.svh @@
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while in reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/core/fvpm_pkg.sv @@
package fvpm_pkg;

  // Component width and derived widths.
  localparam int COMP_BITS = 16;
  localparam int SQ_W      = 2 * COMP_BITS;   // one square, or a sum of up to three squares
  localparam int DIFF_W    = SQ_W + 1;        // E^2 - z^2, signed
  localparam int MSQ_W     = SQ_W + 2;        // mass squared before the sign check
  localparam int REM_W     = COMP_BITS + 2;   // partial remainder of the root
  localparam int RES_W     = 16;              // result field width
  localparam int FRONT_STAGES = 3;
  localparam int LATENCY   = FRONT_STAGES + COMP_BITS;

  typedef struct packed {
    logic [SQ_W-1:0]      rad;   // radicand bits still to bring down, top pair first
    logic [REM_W-1:0]     rem;
    logic [COMP_BITS-1:0] root;
  } root_lane_t;

  typedef struct packed {
    logic       valid;
    logic       invalid;
    root_lane_t pt;
    root_lane_t mass;
  } cell_t;

  // Magnitude of a two's complement component; the most negative value maps to 2^(C-1).
  function automatic logic [COMP_BITS-1:0] comp_mag(input logic signed [COMP_BITS-1:0] c);
    logic [COMP_BITS-1:0] neg;
    neg = COMP_BITS'(~c) + COMP_BITS'(1);
    return c[COMP_BITS-1] ? neg : COMP_BITS'(c);
  endfunction

  // One digit of the restoring square root: bring down two bits, try (root,01).
  function automatic root_lane_t root_step(input root_lane_t l);
    root_lane_t           o;
    logic [REM_W-1:0]     rem_sh;
    logic [REM_W-1:0]     trial;
    logic                 ge;
    rem_sh = {l.rem[REM_W-3:0], l.rad[SQ_W-1 -: 2]};
    trial  = {l.root, 2'b01};
    ge     = (rem_sh >= trial);
    o.rem  = ge ? (rem_sh - trial) : rem_sh;
    o.root = {l.root[COMP_BITS-2:0], ge};
    o.rad  = {l.rad[SQ_W-3:0], 2'b00};
    return o;
  endfunction

endpackage

@@ rtl/core/four_vector_pt_and_mass.sv @@
// A request taken with start passes through three arithmetic stages, then one root cell per bit,
// and gives its done strobe at the end of the root cell chain.
// Throughput: one request per cycle; busy is never raised outside reset.
// Results come out in request order and are held on the ports for the strobe cycle only.
// Reset (rst, synchronous, active high) empties the pipeline; busy is high during reset.
`include "assert_macros.svh"

module four_vector_pt_and_mass (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  start,
  output logic                                  busy,
  input  logic signed [fvpm_pkg::COMP_BITS-1:0] momentum_x,
  input  logic signed [fvpm_pkg::COMP_BITS-1:0] momentum_y,
  input  logic signed [fvpm_pkg::COMP_BITS-1:0] momentum_z,
  input  logic signed [fvpm_pkg::COMP_BITS-1:0] energy,
  output logic                                  done,
  output logic [fvpm_pkg::RES_W-1:0]            transverse_momentum,
  output logic [fvpm_pkg::RES_W-1:0]            invariant_mass,
  output logic                                  mass_invalid
);
  import fvpm_pkg::*;

  logic  accept;
  cell_t chain [0:COMP_BITS];

  assign busy   = rst;
  assign accept = start & ~busy;

  fvpm_front u_front (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .momentum_x (momentum_x),
    .momentum_y (momentum_y),
    .momentum_z (momentum_z),
    .energy     (energy),
    .head       (chain[0])
  );

  for (genvar i = 0; i < COMP_BITS; i++) begin : g_cell
    fvpm_root_cell u_cell (
      .clk (clk),
      .rst (rst),
      .d   (chain[i]),
      .q   (chain[i+1])
    );
  end

  assign done                = chain[COMP_BITS].valid;
  assign transverse_momentum = RES_W'(chain[COMP_BITS].pt.root);
  assign invariant_mass      = RES_W'(chain[COMP_BITS].mass.root);
  assign mass_invalid        = chain[COMP_BITS].invalid;

  `ASSERT_IMPLIES(a_invalid_zero_mass, clk, rst, done && mass_invalid, invariant_mass == '0,
                  "mass not zero for an unphysical vector")
  `ASSERT_IMPLIES(a_done_from_request, clk, rst, done, $past(accept, LATENCY),
                  "result without a matching request")
  `ASSERT_NEXT(a_no_result_after_reset, clk, 1'b0, rst, !done,
               "result straight after reset")

endmodule

@@ rtl/core/fvpm_front.sv @@
module fvpm_front (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  accept,
  input  logic signed [fvpm_pkg::COMP_BITS-1:0] momentum_x,
  input  logic signed [fvpm_pkg::COMP_BITS-1:0] momentum_y,
  input  logic signed [fvpm_pkg::COMP_BITS-1:0] momentum_z,
  input  logic signed [fvpm_pkg::COMP_BITS-1:0] energy,
  output fvpm_pkg::cell_t                       head
);
  import fvpm_pkg::*;

  logic [COMP_BITS-1:0] mag_x, mag_y, mag_z, mag_e;

  // stage 1: squares
  logic            s1_valid;
  logic [SQ_W-1:0] sq_x, sq_y, sq_z, sq_e;
  // stage 2: pt^2 and E^2 - z^2
  logic              s2_valid;
  logic [SQ_W-1:0]   s2_pt_sq;
  logic [DIFF_W-1:0] s2_ez;
  // stage 3: mass squared and its sign
  logic [MSQ_W-1:0] msq;
  logic             s3_valid;
  logic             s3_invalid;
  logic [SQ_W-1:0]  s3_pt_sq;
  logic [SQ_W-1:0]  s3_mass_sq;

  assign mag_x = comp_mag(momentum_x);
  assign mag_y = comp_mag(momentum_y);
  assign mag_z = comp_mag(momentum_z);
  assign mag_e = comp_mag(energy);

  assign msq = {s2_ez[DIFF_W-1], s2_ez} - {2'b00, s2_pt_sq};

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
    end else begin
      s1_valid <= accept;
      s2_valid <= s1_valid;
      s3_valid <= s2_valid;
    end
    sq_x <= SQ_W'(mag_x) * SQ_W'(mag_x);
    sq_y <= SQ_W'(mag_y) * SQ_W'(mag_y);
    sq_z <= SQ_W'(mag_z) * SQ_W'(mag_z);
    sq_e <= SQ_W'(mag_e) * SQ_W'(mag_e);

    s2_pt_sq <= sq_x + sq_y;
    s2_ez    <= {1'b0, sq_e} - {1'b0, sq_z};

    s3_pt_sq   <= s2_pt_sq;
    s3_invalid <= msq[MSQ_W-1];
    // drop a negative mass squared to zero
    s3_mass_sq <= msq[MSQ_W-1] ? '0 : msq[SQ_W-1:0];
  end

  always_comb begin
    head.valid     = s3_valid;
    head.invalid   = s3_invalid;
    head.pt.rad    = s3_pt_sq;
    head.pt.rem    = '0;
    head.pt.root   = '0;
    head.mass.rad  = s3_mass_sq;
    head.mass.rem  = '0;
    head.mass.root = '0;
  end

endmodule

@@ rtl/core/fvpm_root_cell.sv @@
module fvpm_root_cell (
  input  logic            clk,
  input  logic            rst,
  input  fvpm_pkg::cell_t d,
  output fvpm_pkg::cell_t q
);
  import fvpm_pkg::*;

  // one root digit for both lanes, then hand on to the next cell
  always_ff @(posedge clk) begin
    if (rst) begin
      q.valid <= 1'b0;
    end else begin
      q.valid <= d.valid;
    end
    q.invalid <= d.invalid;
    q.pt      <= root_step(d.pt);
    q.mass    <= root_step(d.mass);
  end

endmodule

@@ verif/testbench.sv @@
`timescale 1ns / 100ps

module testbench;
  import fvpm_pkg::*;

  typedef logic signed [COMP_BITS-1:0] comp_t;

  typedef struct {
    comp_t px;
    comp_t py;
    comp_t pz;
    comp_t e;
    int    idle_pct;
    bit    drain_first;
  } vector_request_t;

  typedef struct {
    logic [RES_W-1:0] pt;
    logic [RES_W-1:0] mass;
    logic             invalid;
  } pt_mass_t;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             start = 1'b0;
  logic             busy;
  comp_t            momentum_x = '0;
  comp_t            momentum_y = '0;
  comp_t            momentum_z = '0;
  comp_t            energy = '0;
  logic             done;
  logic [RES_W-1:0] transverse_momentum;
  logic [RES_W-1:0] invariant_mass;
  logic             mass_invalid;

  vector_request_t  pending_vectors[$];
  pt_mass_t         expected_pt_mass[$];
  int               fail_count = 0;

  four_vector_pt_and_mass uut (
    .clk                 (clk),
    .rst                 (rst),
    .start               (start),
    .busy                (busy),
    .momentum_x          (momentum_x),
    .momentum_y          (momentum_y),
    .momentum_z          (momentum_z),
    .energy              (energy),
    .done                (done),
    .transverse_momentum (transverse_momentum),
    .invariant_mass      (invariant_mass),
    .mass_invalid        (mass_invalid)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic logic [63:0] magnitude(comp_t c);
    logic [63:0] v;
    v = 64'(c);
    return c[COMP_BITS-1] ? -v : v;
  endfunction

  // Build the root one bit at a time, keeping each bit whose square still fits.
  function automatic logic [63:0] floor_sqrt(logic [63:0] n);
    logic [63:0] root;
    logic [63:0] trial;
    root = '0;
    for (int b = 31; b >= 0; b--) begin
      trial = root | (64'd1 << b);
      if (trial * trial <= n) root = trial;
    end
    return root;
  endfunction

  function automatic pt_mass_t predict_pt_mass(comp_t px, comp_t py, comp_t pz, comp_t e);
    logic [63:0] ax;
    logic [63:0] ay;
    logic [63:0] az;
    logic [63:0] ae;
    logic [63:0] pt_sq;
    logic [63:0] p_sq;
    logic [63:0] e_sq;
    logic [63:0] root;
    pt_mass_t    r;
    ax = magnitude(px);
    ay = magnitude(py);
    az = magnitude(pz);
    ae = magnitude(e);
    pt_sq = ax * ax + ay * ay;
    p_sq  = pt_sq + az * az;
    e_sq  = ae * ae;
    root = floor_sqrt(pt_sq);
    r.pt = root[RES_W-1:0];
    if (e_sq < p_sq) begin
      r.mass    = '0;
      r.invalid = 1'b1;
    end else begin
      root      = floor_sqrt(e_sq - p_sq);
      r.mass    = root[RES_W-1:0];
      r.invalid = 1'b0;
    end
    return r;
  endfunction

  function automatic comp_t rand_comp(int lim);
    int v;
    v = $urandom_range(0, 2 * lim);
    v = v - lim;
    return comp_t'(v);
  endfunction

  task automatic add_vector(comp_t px, comp_t py, comp_t pz, comp_t e, int idle_pct,
                            bit drain_first);
    vector_request_t req;
    req.px = px;
    req.py = py;
    req.pz = pz;
    req.e = e;
    req.idle_pct = idle_pct;
    req.drain_first = drain_first;
    pending_vectors.push_back(req);
  endtask

  // Driver: present the oldest pending request unless idling or draining.
  always @(negedge clk) begin
    vector_request_t req;
    bit              present;
    present = 1'b0;
    if (!rst && pending_vectors.size() != 0) begin
      req = pending_vectors[0];
      present = !((req.drain_first && expected_pt_mass.size() != 0) ||
                  ($urandom_range(0, 99) < req.idle_pct));
    end
    start      <= present;
    momentum_x <= present ? req.px : comp_t'($urandom);
    momentum_y <= present ? req.py : comp_t'($urandom);
    momentum_z <= present ? req.pz : comp_t'($urandom);
    energy     <= present ? req.e  : comp_t'($urandom);
  end

  // Monitor: check results in order, then record any request taken this edge.
  always @(posedge clk) begin
    pt_mass_t want;
    if (!rst && done !== 1'b0) begin
      if (expected_pt_mass.size() == 0) begin
        $display("%0t: result with nothing expected: pt=%0d mass=%0d invalid=%b", $time,
                 transverse_momentum, invariant_mass, mass_invalid);
        fail_count++;
      end else begin
        want = expected_pt_mass.pop_front();
        if (transverse_momentum !== want.pt) begin
          $display("%0t: transverse_momentum expected %0d actual %0d", $time, want.pt,
                   transverse_momentum);
          fail_count++;
        end
        if (invariant_mass !== want.mass) begin
          $display("%0t: invariant_mass expected %0d actual %0d", $time, want.mass,
                   invariant_mass);
          fail_count++;
        end
        if (mass_invalid !== want.invalid) begin
          $display("%0t: mass_invalid expected %b actual %b", $time, want.invalid,
                   mass_invalid);
          fail_count++;
        end
      end
    end
    if (!rst && start && !busy) begin
      expected_pt_mass.push_back(predict_pt_mass(momentum_x, momentum_y, momentum_z, energy));
      void'(pending_vectors.pop_front());
    end
  end

  initial begin
    comp_t       px;
    comp_t       py;
    comp_t       pz;
    comp_t       e;
    int          idle_pct;
    bit          drain_first;
    logic [63:0] root;

    // Directed: extremes, exact roots, boundary of negative mass squared.
    add_vector(0, 0, 0, 0, 0, 0);
    add_vector(3, 4, 0, 5, 0, 0);
    add_vector(3, 4, 1, 5, 0, 0);
    add_vector(0, 0, 0, -32768, 0, 0);
    add_vector(-32768, -32768, 0, 0, 0, 0);
    add_vector(32767, 32767, 32767, 32767, 0, 0);
    add_vector(-32768, -32768, -32768, -32768, 0, 0);
    add_vector(0, 0, 0, 32767, 0, 0);
    add_vector(0, 0, -32768, -32768, 0, 0);
    add_vector(32767, 0, 0, -32768, 0, 0);
    add_vector(1, 0, 0, -1, 0, 0);
    add_vector(-1, -1, -1, -2, 0, 0);
    add_vector(0, 0, 0, -1, 0, 0);
    add_vector(100, 200, 300, -1000, 0, 0);
    add_vector(comp_t'(16'h5555), comp_t'(16'hAAAA), comp_t'(16'h5555), comp_t'(16'hAAAA),
               0, 0);
    add_vector(comp_t'(16'hAAAA), comp_t'(16'h5555), comp_t'(16'hAAAA), comp_t'(16'h5555),
               0, 0);
    add_vector(12, 5, 0, 13, 0, 0);
    add_vector(0, 0, 1, 0, 0, 0);
    add_vector(1000, -1000, 1000, 1733, 0, 0);
    add_vector(1000, -1000, 1000, -1732, 0, 0);
    add_vector(-32768, 0, 0, 32767, 0, 0);
    add_vector(0, -32768, 0, -32768, 0, 0);
    add_vector(32767, -32768, 0, 32767, 0, 1);

    for (int i = 0; i < 950; i++) begin
      if (i < 200) idle_pct = 0;
      else if (i < 450) idle_pct = 78;
      else if (i < 650) idle_pct = 7;
      else idle_pct = ((i / 40) % 2) ? 30 : 0;
      drain_first = (i == 200 || i == 450 || i == 650 || $urandom_range(0, 99) == 0);
      case ($urandom_range(0, 3))
        0: begin
          px = comp_t'($urandom);
          py = comp_t'($urandom);
          pz = comp_t'($urandom);
          e  = comp_t'($urandom);
        end
        1: begin
          px = rand_comp(300);
          py = rand_comp(300);
          pz = rand_comp(300);
          e  = rand_comp(600);
        end
        2: begin
          // well inside the physical region
          px = rand_comp(8000);
          py = rand_comp(8000);
          pz = rand_comp(8000);
          e  = comp_t'($urandom_range(14000, 32767));
          if ($urandom_range(0, 1)) e = -e;
        end
        default: begin
          // energy right at the edge of mass squared turning negative
          px = rand_comp(18000);
          py = rand_comp(18000);
          pz = rand_comp(18000);
          root = floor_sqrt(magnitude(px) * magnitude(px) + magnitude(py) * magnitude(py) +
                            magnitude(pz) * magnitude(pz));
          root = root + $urandom_range(0, 1);
          e = comp_t'(root);
          if ($urandom_range(0, 1)) e = -e;
        end
      endcase
      add_vector(px, py, pz, e, idle_pct, drain_first);
    end

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (pending_vectors.size() != 0 || expected_pt_mass.size() != 0) @(posedge clk);
    repeat (LATENCY + 5) @(posedge clk);
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("== FAIL ==");
    $finish;
  end

endmodule
